/* hw/rtl/shelf_best_fit_rect_packer_assert.svh */
// Assertion macros for the shelf packer.
`ifndef SHELF_BEST_FIT_RECT_PACKER_ASSERT_SVH
`define SHELF_BEST_FIT_RECT_PACKER_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SBP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shelf packer check failed");

// Next-cycle implication.
`define SBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shelf packer check failed");

`endif

/* hw/rtl/sbfrp_pkg.sv */
// Shared constants and types of the shelf packer.
package sbfrp_pkg;
  localparam int unsigned MaxShelves = 256;
  localparam int unsigned EdgeLimit  = 4096;
  localparam int unsigned IdxW       = $clog2(MaxShelves);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned DimW       = 13;
  localparam int unsigned PosW       = 12;
  // One shelf entry: top, tall, cursor, room.
  localparam int unsigned ShelfW     = PosW + 3 * DimW;

  localparam logic CfgAtlasEdge   = 1'b0;
  localparam logic CfgLeftReserve = 1'b1;

  typedef struct packed {
    logic [PosW-1:0] top;
    logic [DimW-1:0] tall;
    logic [DimW-1:0] cursor;
    logic [DimW-1:0] room;
  } shelf_t;
endpackage

/* hw/rtl/sbfrp_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module sbfrp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/shelf_best_fit_rect_packer.sv */
// Top level of the shelf best-fit rectangle packer.
//
//  channel  dir  handshake              payload
//  s_axis   in   s_axis_tvalid/tready   tdata: rect_width[12:0], rect_height[25:13]; tuser: new_run
//  m_axis   out  m_axis_tvalid/tready   tdata: place_x[11:0], place_y[23:12], outcome[24]
//  cfg      in   cfg_valid_i/ready_o    cfg_index_i selects register, cfg_data_i value
//
// An item is handled in steps: one memory read per open shelf, pipelined
// through the single read port, then a drain, a decision and a write-back.
// Reset initialises the registers but not the shelf memory; the shelf
// memory needs no clearing since only entries below the count are read.
// A waiting result is held in the output register; the next item is accepted
// once the result register is free to be loaded.
module shelf_best_fit_rect_packer
  import sbfrp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // rect_width[12:0], rect_height[25:13]
  input  logic        s_axis_tuser,   // new_run
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // place_x[11:0], place_y[23:12], outcome[24]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  `include "shelf_best_fit_rect_packer_assert.svh"

  typedef enum logic [2:0] {StIdle, StScan, StDrain, StDecide, StWrite} state_e;

  state_e             state_q;
  logic [DimW-1:0]    edge_q, resv_q;
  logic [CntW-1:0]    count_q;
  logic [DimW:0]      used_q;
  logic               failed_q;
  logic [DimW-1:0]    w_q, h_q;
  logic [CntW-1:0]    raddr_q, rcnt_q;
  logic               rvld_q;
  logic               found_q;
  logic [IdxW-1:0]    pick_q;
  shelf_t             best_q;
  logic               ovld_q;
  logic [PosW-1:0]    ox_q, oy_q;
  logic               ofail_q;

  logic               we;
  logic [IdxW-1:0]    waddr;
  shelf_t             wdata, rdata;
  logic [ShelfW-1:0]  rraw;

  sbfrp_ram #(.Width(ShelfW), .Depth(MaxShelves)) u_shelves (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_q[IdxW-1:0]), .rdata_o(rraw)
  );
  assign rdata = shelf_t'(rraw);

  // Effective edge and free width; both fit 14 bits signed.
  logic [DimW-1:0]    edge_eff;
  logic signed [DimW+1:0] avail, edge_s, rest_rows;
  assign edge_eff  = (edge_q > DimW'(EdgeLimit)) ? DimW'(EdgeLimit) : edge_q;
  assign edge_s    = $signed({2'b00, edge_eff});
  assign avail     = edge_s - $signed({2'b00, resv_q});
  assign rest_rows = edge_s - $signed({1'b0, used_q});

  logic in_acc, out_acc;
  assign s_axis_tready = (state_q == StIdle) && !ovld_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;

  // Candidate test for the shelf read back this cycle.
  logic cand;
  assign cand = rvld_q && (rdata.room != '0) && (rdata.room >= w_q) && (rdata.tall >= h_q)
                && (!found_q || rdata.room < best_q.room);

  logic [DimW-1:0] in_w, in_h;
  assign in_w = s_axis_tdata[DimW-1:0];
  assign in_h = s_axis_tdata[2*DimW-1:DimW];

  always_comb begin
    we    = 1'b0;
    waddr = pick_q;
    wdata = best_q;
    if (state_q == StWrite) begin
      we = 1'b1;
      wdata.cursor = best_q.cursor + w_q;
      wdata.room   = best_q.room - w_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      edge_q   <= DimW'(EdgeLimit);
      resv_q   <= '0;
      count_q  <= '0;
      used_q   <= '0;
      failed_q <= 1'b0;
      ovld_q   <= 1'b0;
      rvld_q   <= 1'b0;
      found_q  <= 1'b0;
      raddr_q  <= '0;
      rcnt_q   <= '0;
      w_q      <= '0;
      h_q      <= '0;
      pick_q   <= '0;
      best_q   <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
      ofail_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgAtlasEdge:   edge_q <= cfg_data_i[DimW-1:0];
          CfgLeftReserve: resv_q <= {1'b0, cfg_data_i[PosW-1:0]};
          default: ;
        endcase
      end
      if (out_acc) ovld_q <= 1'b0;
      if (cand) begin
        found_q <= 1'b1;
        best_q  <= rdata;
        pick_q  <= rcnt_q[IdxW-1:0];
      end
      if (rvld_q) rcnt_q <= rcnt_q + 1'b1;
      rvld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            w_q <= in_w;
            h_q <= in_h;
            found_q <= 1'b0;
            raddr_q <= '0;
            rcnt_q  <= '0;
            if (s_axis_tuser) begin
              count_q  <= '0;
              used_q   <= '0;
              failed_q <= 1'b0;
            end
            if (failed_q && !s_axis_tuser) begin
              ovld_q <= 1'b1; ox_q <= '0; oy_q <= '0; ofail_q <= 1'b1;
            end else begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          // Size check first; then issue one read per open shelf.
          if ($signed({2'b00, w_q}) > avail || $signed({2'b00, h_q}) > edge_s) begin
            failed_q <= 1'b1;
            ovld_q <= 1'b1; ox_q <= '0; oy_q <= '0; ofail_q <= 1'b1;
            state_q <= StIdle;
          end else if (raddr_q < count_q) begin
            rvld_q  <= 1'b1;
            raddr_q <= raddr_q + 1'b1;
          end else begin
            state_q <= StDrain;
          end
        end
        StDrain: state_q <= StDecide;
        StDecide: begin
          if (found_q) begin
            state_q <= StWrite;
          end else if ($signed({2'b00, h_q}) > rest_rows
                       || count_q >= CntW'(MaxShelves)) begin
            failed_q <= 1'b1;
            ovld_q <= 1'b1; ox_q <= '0; oy_q <= '0; ofail_q <= 1'b1;
            state_q <= StIdle;
          end else begin
            best_q.top    <= used_q[PosW-1:0];
            best_q.tall   <= h_q;
            best_q.cursor <= resv_q;
            best_q.room   <= avail[DimW-1:0];
            pick_q        <= count_q[IdxW-1:0];
            count_q       <= count_q + 1'b1;
            used_q        <= used_q + {1'b0, h_q};
            state_q       <= StWrite;
          end
        end
        StWrite: begin
          ovld_q  <= 1'b1;
          ox_q    <= best_q.cursor[PosW-1:0];
          oy_q    <= best_q.top;
          ofail_q <= 1'b0;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {7'd0, ofail_q, oy_q, ox_q};

  `SBP_ASSERT_IMP(a_fail_zero, ovld_q && ofail_q, ox_q == '0 && oy_q == '0)
  `SBP_ASSERT_IMP(a_count_max, 1'b1, count_q <= CntW'(MaxShelves))
  `SBP_ASSERT_NEXT(a_write_result, state_q == StWrite, ovld_q && !ofail_q)
endmodule
